// File: rtl/sph_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sph_pkg;

  // Field widths
  localparam int MOD_W     = 31;
  localparam int CHAR_W    = 8;
  localparam int IDX_W     = 13;
  localparam int ACT_W     = 2;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 2;

  // String capacity and memory geometry
  localparam int MAX_LENGTH = 4096;
  localparam int DEPTH      = MAX_LENGTH + 1;
  localparam int LEN_W      = $clog2(MAX_LENGTH + 1);

  // Multiply-reduce unit: product width and remainder bits retired per cycle
  localparam int PROD_W   = 2 * MOD_W;
  localparam int RED_BITS = 2;

  // Register reset values
  localparam logic [MOD_W-1:0] RESET_MODULUS = MOD_W'(1000180033);
  localparam logic [MOD_W-1:0] RESET_BASE    = MOD_W'(100403);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BASE    = CFG_IDX_W'(1);

  // Action codes
  localparam logic [ACT_W-1:0] ACT_BEGIN  = ACT_W'(0);
  localparam logic [ACT_W-1:0] ACT_APPEND = ACT_W'(1);
  localparam logic [ACT_W-1:0] ACT_QUERY  = ACT_W'(2);

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK        = STAT_W'(0);
  localparam logic [STAT_W-1:0] ST_BAD_RANGE = STAT_W'(1);
  localparam logic [STAT_W-1:0] ST_FULL      = STAT_W'(2);

  // Request to the multiply-reduce unit: (a * b + c) mod m
  typedef struct packed {
    logic             start;
    logic [MOD_W-1:0] a;
    logic [MOD_W-1:0] b;
    logic [MOD_W-1:0] c;
    logic [MOD_W-1:0] m;
  } mm_req_t;

  // Response from the multiply-reduce unit
  typedef struct packed {
    logic             done;
    logic [MOD_W-1:0] value;
  } mm_rsp_t;

endpackage

`default_nettype wire

// File: rtl/substring_polynomial_hash.sv
`timescale 1ns / 1ps
`default_nettype none

// Polynomial rolling hash over a stored string. A begin beat empties the
// string and computes the base inverse as base^(modulus-2) by square and
// multiply; an append beat stores the new prefix sum and inverse power and
// returns the prefix sum; a query beat over 1-based positions l..r returns
// (sum[r] - sum[l-1]) * inverse_power[l] mod modulus. Prefix sums and
// inverse powers live in two synchronous RAMs of MAX_LENGTH+1 words; all
// modular arithmetic runs through one shared multiply-reduce unit that
// retires two remainder bits per cycle. A bad range or a full string is
// answered without using the unit. Items are handled one at a time; a
// finished result waits in an output register while the next beat is
// taken.
// Status 1 flags a bad query range, status 2 an append to a full string.
module substring_polynomial_hash (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Item channel
  input  wire logic                            item_valid,
  output logic                                 item_ready,
  input  wire logic [sph_pkg::ACT_W-1:0]       action,
  input  wire logic [sph_pkg::CHAR_W-1:0]      character,
  input  wire logic [sph_pkg::IDX_W-1:0]       first_index,
  input  wire logic [sph_pkg::IDX_W-1:0]       last_index,
  // Result channel
  output logic                                 result_valid,
  input  wire logic                            result_ready,
  output logic      [sph_pkg::MOD_W-1:0]       hash_result,
  output logic      [sph_pkg::STAT_W-1:0]      status,
  // Configuration channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [sph_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sph_pkg::MOD_W-1:0]       cfg_data
);

  localparam int MOD_W = sph_pkg::MOD_W;
  localparam int LEN_W = sph_pkg::LEN_W;
  localparam int IDX_W = sph_pkg::IDX_W;

  typedef enum logic [4:0] {
    S_IDLE,
    S_BG_ACC, S_BG_ACC_W, S_BG_SQ, S_BG_SQ_W,
    S_BG_LOOP, S_BG_MUL, S_BG_MUL_W, S_BG_SQR, S_BG_SQR_W,
    S_AP_CHK, S_AP_RP, S_AP_RP_W, S_AP_RIP, S_AP_RIP_W, S_AP_HASH, S_AP_HASH_W,
    S_QR_CHK, S_QR_A, S_QR_A_W, S_QR_B, S_QR_B_W, S_QR_D, S_QR_M, S_QR_M_W,
    S_EMIT
  } state_t;

  state_t                       state;
  logic [MOD_W-1:0]             modulus;
  logic [MOD_W-1:0]             base;
  logic [LEN_W-1:0]             len;
  logic [MOD_W-1:0]             rp;
  logic [MOD_W-1:0]             rip;
  logic [MOD_W-1:0]             binv;
  logic [MOD_W-1:0]             acc;
  logic [MOD_W-1:0]             sq;
  logic [MOD_W-1:0]             expo;
  logic [MOD_W-1:0]             a_red;
  logic [MOD_W:0]               dsum;
  logic [MOD_W-1:0]             diff;
  logic [MOD_W-1:0]             ipl;
  logic [sph_pkg::CHAR_W-1:0]   ch_q;
  logic [IDX_W-1:0]             l_q;
  logic [IDX_W-1:0]             r_q;
  logic [MOD_W-1:0]             res_hash;
  logic [sph_pkg::STAT_W-1:0]   res_status;

  sph_pkg::mm_req_t             mm_req;
  sph_pkg::mm_rsp_t             mm_rsp;

  logic                         ps_we;
  logic [LEN_W-1:0]             ps_waddr;
  logic [MOD_W-1:0]             ps_wdata;
  logic                         ps_re;
  logic [LEN_W-1:0]             ps_raddr;
  logic [MOD_W-1:0]             ps_rdata;
  logic                         ip_we;
  logic                         ip_re;
  logic [LEN_W-1:0]             ip_raddr;
  logic [MOD_W-1:0]             ip_rdata;

  logic [LEN_W-1:0]             len_inc;
  logic                         is_full;
  logic                         bad_range;
  logic [MOD_W-1:0]             fermat_exp;

  assign item_ready = (state == S_IDLE);
  assign cfg_ready  = 1'b1;

  assign len_inc    = len + LEN_W'(1);
  assign is_full    = (int'(len) >= sph_pkg::MAX_LENGTH);
  assign bad_range  = (l_q == '0) || (l_q > r_q) || (int'(r_q) > int'(len));
  assign fermat_exp = (modulus >= MOD_W'(2)) ? modulus - MOD_W'(2) : '0;

  // Drive the shared multiply-reduce unit from the current step
  always_comb begin
    mm_req       = '0;
    mm_req.m     = modulus;
    mm_req.start = 1'b1;
    unique case (state)
      S_BG_ACC:  begin mm_req.a = MOD_W'(1); mm_req.b = MOD_W'(1); end
      S_BG_SQ:   begin mm_req.a = base;      mm_req.b = MOD_W'(1); end
      S_BG_MUL:  begin mm_req.a = acc;       mm_req.b = sq;        end
      S_BG_SQR:  begin mm_req.a = sq;        mm_req.b = sq;        end
      S_AP_RP:   begin mm_req.a = rp;        mm_req.b = base;      end
      S_AP_RIP:  begin mm_req.a = rip;       mm_req.b = binv;      end
      S_AP_HASH: begin
        mm_req.a = rp;
        mm_req.b = MOD_W'(ch_q);
        mm_req.c = ps_rdata;
      end
      S_QR_A:    begin mm_req.a = ps_rdata;  mm_req.b = MOD_W'(1); end
      S_QR_B:    begin mm_req.a = ps_rdata;  mm_req.b = MOD_W'(1); end
      S_QR_M:    begin mm_req.a = diff;      mm_req.b = ipl;       end
      default:   mm_req.start = 1'b0;
    endcase
  end

  // Memory ports: one read and one write per RAM
  always_comb begin
    ps_we    = 1'b0;
    ps_waddr = len_inc;
    ps_wdata = mm_rsp.value;
    ps_re    = 1'b0;
    ps_raddr = len;
    ip_we    = (state == S_AP_HASH_W) && mm_rsp.done;
    ip_re    = (state == S_QR_CHK) && !bad_range;
    ip_raddr = LEN_W'(l_q);
    unique case (state)
      S_BG_ACC: begin
        ps_we    = 1'b1;
        ps_waddr = '0;
        ps_wdata = '0;
      end
      S_AP_HASH_W: ps_we = mm_rsp.done;
      S_AP_CHK:    ps_re = !is_full;
      S_QR_CHK: begin
        ps_re    = !bad_range;
        ps_raddr = LEN_W'(r_q);
      end
      S_QR_A: begin
        ps_re    = 1'b1;
        ps_raddr = LEN_W'(l_q - IDX_W'(1));
      end
      default: ps_re = 1'b0;
    endcase
  end

  sph_mulmod u_mulmod (
    .clk (clk),
    .rst (rst),
    .req (mm_req),
    .rsp (mm_rsp)
  );

  sph_ram #(
    .WIDTH (MOD_W),
    .DEPTH (sph_pkg::DEPTH)
  ) u_prefix_ram (
    .clk   (clk),
    .we    (ps_we),
    .waddr (ps_waddr),
    .wdata (ps_wdata),
    .re    (ps_re),
    .raddr (ps_raddr),
    .rdata (ps_rdata)
  );

  sph_ram #(
    .WIDTH (MOD_W),
    .DEPTH (sph_pkg::DEPTH)
  ) u_invpow_ram (
    .clk   (clk),
    .we    (ip_we),
    .waddr (len_inc),
    .wdata (rip),
    .re    (ip_re),
    .raddr (ip_raddr),
    .rdata (ip_rdata)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= sph_pkg::RESET_MODULUS;
      base    <= sph_pkg::RESET_BASE;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == sph_pkg::REG_MODULUS) begin
        modulus <= cfg_data;
      end else if (cfg_index == sph_pkg::REG_BASE) begin
        base <= cfg_data;
      end
    end
  end

  // Sequencer: one item at a time through the shared unit
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      len          <= '0;
      rp           <= MOD_W'(1);
      rip          <= MOD_W'(1);
      binv         <= '0;
    end else begin
      // drop the result once taken, unless a new one replaces it
      if ((state != S_EMIT) && result_valid && result_ready) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            ch_q       <= character;
            l_q        <= first_index;
            r_q        <= last_index;
            res_hash   <= '0;
            res_status <= sph_pkg::ST_OK;
            unique case (action)
              sph_pkg::ACT_BEGIN:  state <= S_BG_ACC;
              sph_pkg::ACT_APPEND: state <= S_AP_CHK;
              sph_pkg::ACT_QUERY:  state <= S_QR_CHK;
              default:             state <= S_EMIT;
            endcase
          end
        end

        // Begin: base^(modulus-2) by square and multiply
        S_BG_ACC:   state <= S_BG_ACC_W;
        S_BG_ACC_W: begin
          if (mm_rsp.done) begin
            acc   <= mm_rsp.value;
            state <= S_BG_SQ;
          end
        end
        S_BG_SQ:    state <= S_BG_SQ_W;
        S_BG_SQ_W: begin
          if (mm_rsp.done) begin
            sq    <= mm_rsp.value;
            expo  <= fermat_exp;
            state <= S_BG_LOOP;
          end
        end
        S_BG_LOOP: begin
          if (expo == '0) begin
            binv  <= acc;
            rp    <= MOD_W'(1);
            rip   <= MOD_W'(1);
            len   <= '0;
            state <= S_EMIT;
          end else if (expo[0]) begin
            state <= S_BG_MUL;
          end else begin
            state <= S_BG_SQR;
          end
        end
        S_BG_MUL:   state <= S_BG_MUL_W;
        S_BG_MUL_W: begin
          if (mm_rsp.done) begin
            acc   <= mm_rsp.value;
            state <= S_BG_SQR;
          end
        end
        S_BG_SQR:   state <= S_BG_SQR_W;
        S_BG_SQR_W: begin
          if (mm_rsp.done) begin
            sq    <= mm_rsp.value;
            expo  <= expo >> 1;
            state <= S_BG_LOOP;
          end
        end

        // Append: advance the powers, then fold the byte into the prefix sum
        S_AP_CHK: begin
          if (is_full) begin
            res_status <= sph_pkg::ST_FULL;
            state      <= S_EMIT;
          end else begin
            state <= S_AP_RP;
          end
        end
        S_AP_RP:    state <= S_AP_RP_W;
        S_AP_RP_W: begin
          if (mm_rsp.done) begin
            rp    <= mm_rsp.value;
            state <= S_AP_RIP;
          end
        end
        S_AP_RIP:   state <= S_AP_RIP_W;
        S_AP_RIP_W: begin
          if (mm_rsp.done) begin
            rip   <= mm_rsp.value;
            state <= S_AP_HASH;
          end
        end
        S_AP_HASH:  state <= S_AP_HASH_W;
        S_AP_HASH_W: begin
          if (mm_rsp.done) begin
            res_hash <= mm_rsp.value;
            len      <= len_inc;
            state    <= S_EMIT;
          end
        end

        // Query: reduce both sums, subtract, scale by the inverse power
        S_QR_CHK: begin
          if (bad_range) begin
            res_status <= sph_pkg::ST_BAD_RANGE;
            state      <= S_EMIT;
          end else begin
            state <= S_QR_A;
          end
        end
        S_QR_A: begin
          ipl   <= ip_rdata;
          state <= S_QR_A_W;
        end
        S_QR_A_W: begin
          if (mm_rsp.done) begin
            a_red <= mm_rsp.value;
            state <= S_QR_B;
          end
        end
        S_QR_B:     state <= S_QR_B_W;
        S_QR_B_W: begin
          if (mm_rsp.done) begin
            dsum  <= {1'b0, a_red} + {1'b0, modulus} - {1'b0, mm_rsp.value};
            state <= S_QR_D;
          end
        end
        S_QR_D: begin
          diff  <= (dsum >= {1'b0, modulus}) ? MOD_W'(dsum - {1'b0, modulus})
                                             : dsum[MOD_W-1:0];
          state <= S_QR_M;
        end
        S_QR_M:     state <= S_QR_M_W;
        S_QR_M_W: begin
          if (mm_rsp.done) begin
            res_hash <= mm_rsp.value;
            state    <= S_EMIT;
          end
        end

        // Hold the result until the output register is free
        S_EMIT: begin
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            hash_result  <= res_hash;
            status       <= res_status;
            state        <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // String length never passes capacity
  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    int'(len) <= sph_pkg::MAX_LENGTH)
    else $error("string length beyond capacity");

  // Error results carry a zero hash
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status != sph_pkg::ST_OK) |-> (hash_result == '0))
    else $error("error result with nonzero hash");

  // The multiply-reduce unit is quiet whenever a new item may enter
  a_unit_idle: assert property (@(posedge clk) disable iff (rst)
    item_ready |-> !mm_rsp.done)
    else $error("unit response while idle");

  // A completed append grows the string by one
  a_append_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_AP_HASH_W && mm_rsp.done) |=> (len == $past(len_inc)))
    else $error("append did not advance length");

endmodule

`default_nettype wire

// File: rtl/sph_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/sph_mulmod.sv
`timescale 1ns / 1ps
`default_nettype none

module sph_mulmod (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire sph_pkg::mm_req_t req,
  output sph_pkg::mm_rsp_t      rsp
);

  localparam int STEPS = sph_pkg::PROD_W / sph_pkg::RED_BITS;
  localparam int CNT_W = $clog2(STEPS);

  typedef enum logic [1:0] {
    M_IDLE,
    M_ADD,
    M_RED
  } mm_state_t;

  mm_state_t                       state;
  logic [sph_pkg::PROD_W-1:0]      prod;
  logic [sph_pkg::PROD_W-1:0]      val;
  logic [sph_pkg::MOD_W-1:0]       c_q;
  logic [sph_pkg::MOD_W-1:0]       m_q;
  logic [sph_pkg::MOD_W-1:0]       rem;
  logic [sph_pkg::MOD_W-1:0]       rem_next;
  logic [CNT_W-1:0]                cnt;

  // Retire RED_BITS quotient bits: shift in a bit, subtract the modulus if it fits
  always_comb begin
    logic [sph_pkg::MOD_W:0]   t;
    logic [sph_pkg::MOD_W-1:0] r;
    r = rem;
    for (int k = 0; k < sph_pkg::RED_BITS; k++) begin
      t = {r, val[sph_pkg::PROD_W-1-k]};
      if (t >= {1'b0, m_q}) begin
        t = t - {1'b0, m_q};
      end
      r = t[sph_pkg::MOD_W-1:0];
    end
    rem_next = r;
  end

  // Multiply, add the offset, then reduce RED_BITS bits a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= M_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= (state == M_RED) && (cnt == '0);
      unique case (state)
        M_IDLE: begin
          if (req.start) begin
            prod  <= sph_pkg::PROD_W'(req.a) * sph_pkg::PROD_W'(req.b);
            c_q   <= req.c;
            m_q   <= req.m;
            state <= M_ADD;
          end
        end
        M_ADD: begin
          val   <= prod + sph_pkg::PROD_W'(c_q);
          rem   <= '0;
          cnt   <= CNT_W'(STEPS - 1);
          state <= M_RED;
        end
        M_RED: begin
          val <= val << sph_pkg::RED_BITS;
          rem <= rem_next;
          if (cnt == '0) begin
            rsp.value <= (m_q == '0) ? '0 : rem_next;
            state     <= M_IDLE;
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
